// ===== hdl/crs_pkg.sv =====
`default_nettype none

package crs_pkg;

  // Channel store
  localparam int unsigned CHANNELS = 8;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned ChanAw   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int unsigned CountW   = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TagW     = 16;
  localparam int unsigned ResW     = 16;
  localparam int unsigned StateW   = CountW + TimeW;

  // Packed stream widths
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 64;

  // Fixed point: rate is Q32.8
  localparam int unsigned FracW    = 8;
  localparam int unsigned RateW    = CountW + FracW;
  localparam int unsigned Div2Steps = 16;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinSource = 2'd0,
    CfgMaxSource = 2'd1,
    CfgMinDest   = 2'd2,
    CfgMaxDest   = 2'd3
  } cfg_idx_e;

  localparam logic [31:0] MinSourceRst = 32'd0;
  localparam logic [31:0] MaxSourceRst = 32'd3000;
  localparam logic [15:0] MinDestRst   = 16'h0000;
  localparam logic [15:0] MaxDestRst   = 16'hFFFF;

endpackage

`default_nettype wire

// ===== hdl/crs_ram.sv =====
`default_nettype none

module crs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/counter_rate_scaler.sv =====
`default_nettype none

// Counter rate scaler: turns per-channel counter samples into a rate and
// maps that rate linearly onto a 16-bit destination range.
//
// Input stream (s_axis): one sample per transfer, channel number on tuser.
// Output stream (m_axis): one result per sample, in sample order.
// Config channel (cfg_*): register index and data, always ready; write only
// while no sample is in flight.
//
// Timing: one sample at a time. The longest path from the input transfer to
// the result being offered runs through the channel store read, 40 steps of
// the bit-serial divider for the Q32.8 rate, the operand setup, split
// multiply, sum and range check, 16 divider steps for the mapping, the final
// clamp and the load of the output register. Elapsed time that is not
// positive, equal source bounds or a clamped result skip divider passes.
// The next sample is taken the cycle after the load; the shared
// one-bit-per-cycle divider sets the pace.
// If the receiver stalls, a finished result waits in the output register and
// the next one in the last state; no sample is accepted meanwhile.
// Reset clears the per-channel valid bits and restores the register defaults.

module counter_rate_scaler
  import crs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata: raw_count[31:0], time_seconds[63:32], dest_register[79:64]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: chan[2:0]
  input  wire logic [ChanW-1:0]    s_axis_tuser_i,
  // Output stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // tdata: scaled_rate[15:0], count_high[31:16], count_low[47:32],
  //        dest_register_out[63:48]
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // Configuration
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StDiv1,
    StMap,
    StMulLo,
    StMulHi,
    StSum,
    StCheck,
    StDiv2,
    StFinal,
    StOut
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [31:0] min_source_q, max_source_q;
  logic [15:0] min_dest_q, max_dest_q;

  // Sample under work
  logic [ChanW-1:0]  chan_q;
  logic [CountW-1:0] count_q;
  logic [TimeW-1:0]  time_q;
  logic [TagW-1:0]   tag_q;

  // Shared divider
  logic [31:0]      rem_q;
  logic [RateW-1:0] num_q;
  logic [31:0]      dvsr_q;
  logic [5:0]       cnt_q;

  // Mapping
  logic [RateW-1:0] n0mag_q;
  logic [15:0]      dmag_q;
  logic             neg_q;
  logic             dneg_q;
  logic [35:0]      plo_q, phi_q;
  logic [55:0]      n_q;
  logic [ResW-1:0]  res_q;

  // Output register
  logic                m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;
  logic                out_load;

  // Channel store
  logic [CHANNELS-1:0] vld_q;
  logic [StateW-1:0]   ram_rdata;
  logic                ram_re, ram_we;
  logic [ChanAw-1:0]   raddr, waddr;
  logic                chan_ok;

  logic              in_xfer;
  logic [CountW-1:0] prev_count;
  logic [TimeW-1:0]  prev_time;
  logic [CountW-1:0] dcount;
  logic [TimeW-1:0]  dtime;

  // Divider step
  logic [32:0] div_t, div_diff;
  logic        div_ge;

  // Mapping helpers
  logic signed [41:0] num0;
  logic signed [16:0] dspan;
  logic signed [32:0] sdiff;
  logic        over;
  logic [15:0] quo;
  logic        rem_nz;

  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign out_load        = (state_q == StOut) && (!m_tvalid_q || m_axis_tready_i);

  assign raddr   = s_axis_tuser_i[ChanAw-1:0];
  assign waddr   = chan_q[ChanAw-1:0];
  assign ram_re  = in_xfer;
  assign chan_ok = (32'(chan_q) < 32'(CHANNELS));
  assign ram_we  = (state_q == StLoad) && chan_ok;

  crs_ram #(
    .WIDTH(StateW),
    .DEPTH(CHANNELS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i({time_q, count_q}),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    // never-written or out-of-range channels read as the reset values
    if (chan_ok && vld_q[waddr]) begin
      prev_count = ram_rdata[CountW-1:0];
      prev_time  = ram_rdata[StateW-1:CountW];
    end else begin
      prev_count = '0;
      prev_time  = '0;
    end
    dcount = count_q - prev_count;
    dtime  = time_q - prev_time;
  end

  always_comb begin
    div_t    = {rem_q, num_q[RateW-1]};
    div_diff = div_t - {1'b0, dvsr_q};
    div_ge   = (div_t >= {1'b0, dvsr_q});
  end

  always_comb begin
    num0   = $signed({2'b00, num_q}) - $signed({2'b00, min_source_q, 8'h00});
    dspan  = $signed({1'b0, max_dest_q}) - $signed({1'b0, min_dest_q});
    sdiff  = $signed({1'b0, max_source_q}) - $signed({1'b0, min_source_q});
    over   = (n_q[55:24] >= dvsr_q);
    quo    = num_q[15:0];
    rem_nz = (rem_q != '0) || (n_q[7:0] != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      min_source_q <= MinSourceRst;
      max_source_q <= MaxSourceRst;
      min_dest_q   <= MinDestRst;
      max_dest_q   <= MaxDestRst;
      vld_q        <= '0;
      chan_q       <= '0;
      count_q      <= '0;
      time_q       <= '0;
      tag_q        <= '0;
      rem_q        <= '0;
      num_q        <= '0;
      dvsr_q       <= '0;
      cnt_q        <= '0;
      n0mag_q      <= '0;
      dmag_q       <= '0;
      neg_q        <= 1'b0;
      dneg_q       <= 1'b0;
      plo_q        <= '0;
      phi_q        <= '0;
      n_q          <= '0;
      res_q        <= '0;
      m_tvalid_q   <= 1'b0;
      m_tdata_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgMinSource: min_source_q <= cfg_data_i;
          CfgMaxSource: max_source_q <= cfg_data_i;
          CfgMinDest:   min_dest_q   <= cfg_data_i[15:0];
          CfgMaxDest:   max_dest_q   <= cfg_data_i[15:0];
        endcase
      end

      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tvalid_q && m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            chan_q  <= s_axis_tuser_i;
            count_q <= s_axis_tdata_i[31:0];
            time_q  <= s_axis_tdata_i[63:32];
            tag_q   <= s_axis_tdata_i[79:64];
            state_q <= StLoad;
          end
        end
        StLoad: begin
          if (chan_ok) begin
            vld_q[waddr] <= 1'b1;
          end
          // elapsed time positive only when now > previous (unsigned)
          if (time_q > prev_time) begin
            num_q   <= {dcount, {FracW{1'b0}}};
            rem_q   <= '0;
            dvsr_q  <= dtime;
            cnt_q   <= 6'(RateW - 1);
            state_q <= StDiv1;
          end else begin
            num_q   <= '0;
            state_q <= StMap;
          end
        end
        StDiv1, StDiv2: begin
          rem_q <= div_ge ? div_diff[31:0] : div_t[31:0];
          num_q <= {num_q[RateW-2:0], div_ge};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            state_q <= (state_q == StDiv1) ? StMap : StFinal;
          end
        end
        StMap: begin
          if (max_source_q == min_source_q) begin
            res_q   <= min_dest_q;
            state_q <= StOut;
          end else begin
            n0mag_q <= num0[41] ? RateW'(-num0) : num0[RateW-1:0];
            dmag_q  <= dspan[16] ? 16'(-dspan) : dspan[15:0];
            dneg_q  <= dspan[16];
            dvsr_q  <= sdiff[32] ? 32'(-sdiff) : sdiff[31:0];
            neg_q   <= num0[41] ^ dspan[16] ^ sdiff[32];
            state_q <= StMulLo;
          end
        end
        StMulLo: begin
          plo_q   <= n0mag_q[19:0] * dmag_q;
          state_q <= StMulHi;
        end
        StMulHi: begin
          phi_q   <= n0mag_q[39:20] * dmag_q;
          state_q <= StSum;
        end
        StSum: begin
          n_q     <= {phi_q, 20'h00000} + {20'h00000, plo_q};
          state_q <= StCheck;
        end
        StCheck: begin
          priority if (neg_q && (n_q != '0)) begin
            res_q   <= min_dest_q;
            state_q <= StOut;
          end else if (dneg_q) begin
            // inverted destination range: whatever the branch above lets through clamps high
            res_q   <= max_dest_q;
            state_q <= StOut;
          end else if (dmag_q == '0) begin
            res_q   <= min_dest_q;
            state_q <= StOut;
          end else if (over) begin
            res_q   <= max_dest_q;
            state_q <= StOut;
          end else begin
            // quotient of (n >> 8) / span fits 16 bits here
            rem_q   <= n_q[55:24];
            num_q   <= {n_q[23:8], 24'h000000};
            cnt_q   <= 6'(Div2Steps - 1);
            state_q <= StDiv2;
          end
        end
        StFinal: begin
          if ((quo > dmag_q) || ((quo == dmag_q) && rem_nz)) begin
            res_q <= max_dest_q;
          end else begin
            res_q <= min_dest_q + quo;
          end
          state_q <= StOut;
        end
        StOut: begin
          if (out_load) begin
            m_tdata_q  <= {tag_q, count_q[15:0], count_q[31:16], res_q};
            state_q    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire
